@@ hdl/crv_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the config record validator.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package crv_pkg;

   localparam int MAX_RECORD_BYTES = 2048;
   localparam int IDX_W            = 12;
   localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_RECORD_BYTES + 1);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_RECORD_BYTES);

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [31:0] MAGIC_RESET   = 32'hA55A5AA5;
   localparam logic [15:0] VERSION_RESET = 16'h0001;
   localparam logic [11:0] SLOT_RESET    = 12'd64;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT    = 2'd2;

   // status codes
   localparam logic [2:0] ST_VALID   = 3'd0;
   localparam logic [2:0] ST_MAGIC   = 3'd1;
   localparam logic [2:0] ST_VERSION = 3'd2;
   localparam logic [2:0] ST_SIZE    = 3'd3;
   localparam logic [2:0] ST_LENGTH  = 3'd4;
   localparam logic [2:0] ST_CRC     = 3'd5;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] generation;
      logic [31:0] computed_crc;
      logic [31:0] stored_crc;
   } rsp_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hdl/crv_if.sv @@
// Valid/ready channel interfaces: record byte input, result output, register writes.
// Depends on crv_pkg for widths.
interface crv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface crv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] generation;
   logic [31:0] computed_crc;
   logic [31:0] stored_crc;
   modport source (output valid, output status, output generation, output computed_crc,
                   output stored_crc, input ready);
   modport sink   (input valid, input status, input generation, input computed_crc,
                   input stored_crc, output ready);
endinterface

interface crv_csr_if;
   logic                            valid;
   logic                            ready;
   logic [crv_pkg::CSR_IDX_W-1:0]   index;
   logic [31:0]                     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/crv_rsp_queue.sv @@
// Two-entry result queue driving the result channel.
// Depends on crv_pkg (rsp_type) and crv_if.sv (crv_rsp_if).
module crv_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  crv_pkg::rsp_type push_data,
   output logic             full,
   crv_rsp_if.source        rsp_chan
);

   logic             v0_ff, v0_in, v1_ff, v1_in;
   crv_pkg::rsp_type d0_ff, d0_in, d1_ff, d1_in;
   logic             pop;

   assign pop  = v0_ff && rsp_chan.ready;
   assign full = v1_ff;

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      d0_in = d0_ff;
      d1_in = d1_ff;
      if (pop) begin
         if (v1_ff) begin
            d0_in = d1_ff;
            v1_in = 1'b0;
         end else begin
            v0_in = 1'b0;
         end
      end
      if (push) begin
         if (!v0_in) begin
            v0_in = 1'b1;
            d0_in = push_data;
         end else begin
            v1_in = 1'b1;
            d1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
      d0_ff <= d0_in;
      d1_ff <= d1_in;
   end

   assign rsp_chan.valid        = v0_ff;
   assign rsp_chan.status       = d0_ff.status;
   assign rsp_chan.generation   = d0_ff.generation;
   assign rsp_chan.computed_crc = d0_ff.computed_crc;
   assign rsp_chan.stored_crc   = d0_ff.stored_crc;

endmodule

@@ hdl/config_record_validator_top.sv @@
// Config record validator: checks a stored record streamed one byte per beat.
// The result is registered into the output queue at the edge that takes the last byte.
// Throughput: one byte per cycle; input stalls only while two results wait in the queue.
// Reset (synchronous, active high) restores register defaults and clears the record.
// Depends on crv_pkg, crv_if.sv and crv_rsp_queue.
module config_record_validator_top (
   input  logic      clock,
   input  logic      reset,
   crv_req_if.sink   req_chan,
   crv_rsp_if.source rsp_chan,
   crv_csr_if.sink   csr_chan
);

   // ---------------- configuration registers ----------------
   logic [31:0] magic_cfg_ff;
   logic [15:0] version_cfg_ff;
   logic [11:0] slot_cfg_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff   <= crv_pkg::MAGIC_RESET;
         version_cfg_ff <= crv_pkg::VERSION_RESET;
         slot_cfg_ff    <= crv_pkg::SLOT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            crv_pkg::CSR_MAGIC:   magic_cfg_ff   <= csr_chan.data;
            crv_pkg::CSR_VERSION: version_cfg_ff <= csr_chan.data[15:0];
            crv_pkg::CSR_SLOT:    slot_cfg_ff    <= csr_chan.data[11:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // ---------------- record state ----------------
   logic [crv_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] magic_ff, magic_in;
   logic [15:0] version_ff, version_in;
   logic [15:0] size_ff, size_in;
   logic [31:0] gen_ff, gen_in;
   logic [31:0] trailer_ff, trailer_in;   // 4-byte delay line, newest byte on top

   logic             full;
   logic             beat;
   logic             push;
   logic [2:0]       status;
   crv_pkg::rsp_type push_data;

   // ready drops only while two results wait in the queue; every byte stalls then
   assign req_chan.ready = !full;
   assign beat = req_chan.valid && req_chan.ready;
   assign push = beat && req_chan.last;

   // next record state for the incoming byte
   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      size_in    = size_ff;
      gen_in     = gen_ff;
      // header capture, little-endian
      case (idx_ff)
         12'd0:  magic_in[7:0]    = req_chan.data_byte;
         12'd1:  magic_in[15:8]   = req_chan.data_byte;
         12'd2:  magic_in[23:16]  = req_chan.data_byte;
         12'd3:  magic_in[31:24]  = req_chan.data_byte;
         12'd4:  version_in[7:0]  = req_chan.data_byte;
         12'd5:  version_in[15:8] = req_chan.data_byte;
         12'd6:  size_in[7:0]     = req_chan.data_byte;
         12'd7:  size_in[15:8]    = req_chan.data_byte;
         12'd8:  gen_in[7:0]      = req_chan.data_byte;
         12'd9:  gen_in[15:8]     = req_chan.data_byte;
         12'd10: gen_in[23:16]    = req_chan.data_byte;
         12'd11: gen_in[31:24]    = req_chan.data_byte;
         default: ;  // payload and trailer bytes
      endcase
      // byte leaving the delay line enters the CRC once four are held
      crc_in     = (idx_ff >= 12'd4) ? crv_pkg::crc_feed(crc_ff, trailer_ff[7:0]) : crc_ff;
      trailer_in = {req_chan.data_byte, trailer_ff[31:8]};
      idx_in     = (idx_ff < crv_pkg::IDX_SAT) ? idx_ff + 12'd1 : idx_ff;
   end

   // first failing check wins
   always_comb begin
      if (magic_in != magic_cfg_ff) begin
         status = crv_pkg::ST_MAGIC;
      end else if (version_in != version_cfg_ff) begin
         status = crv_pkg::ST_VERSION;
      end else if (size_in != {4'd0, slot_cfg_ff}) begin
         status = crv_pkg::ST_SIZE;
      end else if (idx_in != slot_cfg_ff || idx_in > crv_pkg::IDX_MAX) begin
         status = crv_pkg::ST_LENGTH;
      end else if (~crc_in != trailer_in) begin
         status = crv_pkg::ST_CRC;
      end else begin
         status = crv_pkg::ST_VALID;
      end
   end

   assign push_data.status       = status;
   assign push_data.generation   = gen_in;
   assign push_data.computed_crc = ~crc_in;
   assign push_data.stored_crc   = trailer_in;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         // last byte clears the record for the next one
         idx_ff     <= '0;
         crc_ff     <= crv_pkg::CRC_INIT;
         magic_ff   <= '0;
         version_ff <= '0;
         size_ff    <= '0;
         gen_ff     <= '0;
         trailer_ff <= '0;
      end else if (beat) begin
         idx_ff     <= idx_in;
         crc_ff     <= crc_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         size_ff    <= size_in;
         gen_ff     <= gen_in;
         trailer_ff <= trailer_in;
      end
   end

   // ---------------- result queue ----------------
   crv_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .rsp_chan  (rsp_chan)
   );

   // ---------------- assertions ----------------
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      push |=> idx_ff == '0 && crc_ff == crv_pkg::CRC_INIT)
      else $error("record state not cleared after last byte");

   a_index_advances: assert property (@(posedge clock) disable iff (reset)
      beat && !req_chan.last |=> idx_ff != '0)
      else $error("byte index did not advance");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= crv_pkg::IDX_SAT)
      else $error("byte index past saturation");

   a_crc_idle: assert property (@(posedge clock) disable iff (reset)
      !beat |=> $stable(crc_ff) && $stable(idx_ff))
      else $error("record state moved without a beat");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_chan.valid)
      else $error("no result after last byte");

endmodule

@@ verif/tb_top.sv @@
// Testbench for config_record_validator_top: streams records byte by byte, predicts status,
// generation and both CRC words, and checks each result beat. Depends on crv_pkg, crv_if.sv
// and the validator RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 6;
   localparam int RECORDS     = 5;   // random records per phase
   // index 3 maps to no register; writes to it must be dropped
   localparam logic [crv_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {
      REC_GOOD,
      REC_BAD_MAGIC,
      REC_BAD_VERSION,
      REC_BAD_SIZE,
      REC_SHORT,
      REC_LONG,
      REC_BAD_CRC,
      REC_NOISE
   } rec_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } rec_beat_type;

   logic clock;
   logic reset;
   logic no_gaps;       // when set, neither side idles
   int   cycle_count;
   int   mismatch_count;

   crv_req_if req_if ();
   crv_rsp_if rsp_if ();
   crv_csr_if csr_if ();

   config_record_validator_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // register shadow, updated when a write beat is taken
   logic [31:0] cfg_magic;
   logic [15:0] cfg_version;
   logic [11:0] cfg_slot;

   // record tracker: mirrors the block's per-record state
   logic [11:0] rec_count;
   logic [31:0] rec_crc;
   logic [31:0] rec_magic;
   logic [15:0] rec_version;
   logic [15:0] rec_size;
   logic [31:0] rec_gen;
   logic [31:0] rec_tail;    // last four bytes seen, newest in the top byte

   rec_beat_type     pending_beats[$];     // record bytes waiting for the driver
   crv_pkg::rsp_type expected_results[$];  // verdicts not yet seen on the result channel
   rec_beat_type     next_beat;
   crv_pkg::rsp_type result_want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] acc;
      acc = crc ^ {24'd0, b};
      repeat (8) acc = (acc >> 1) ^ (crv_pkg::CRC_POLY & {32{acc[0]}});
      return acc;
   endfunction

   function automatic void clear_record();
      rec_count   = '0;
      rec_crc     = crv_pkg::CRC_INIT;
      rec_magic   = '0;
      rec_version = '0;
      rec_size    = '0;
      rec_gen     = '0;
      rec_tail    = '0;
   endfunction

   // Advance the tracker by one accepted byte; on the last byte queue the verdict.
   function automatic void track_byte(input logic [7:0] b, input logic last);
      int               pos;
      logic [2:0]       code;
      crv_pkg::rsp_type res;
      pos = int'(rec_count);
      if (pos < 4) rec_magic[pos*8 +: 8] = b;
      else if (pos < 6) rec_version[(pos-4)*8 +: 8] = b;
      else if (pos < 8) rec_size[(pos-6)*8 +: 8] = b;
      else if (pos < 12) rec_gen[(pos-8)*8 +: 8] = b;
      // once four bytes are held, the byte leaving the window goes into the CRC
      if (pos >= 4) rec_crc = crc32_byte(rec_crc, rec_tail[7:0]);
      rec_tail = {b, rec_tail[31:8]};
      if (rec_count < crv_pkg::IDX_SAT) rec_count = rec_count + 1'b1;
      if (last) begin
         if (rec_magic != cfg_magic) code = crv_pkg::ST_MAGIC;
         else if (rec_version != cfg_version) code = crv_pkg::ST_VERSION;
         else if (rec_size != {4'd0, cfg_slot}) code = crv_pkg::ST_SIZE;
         else if (rec_count != cfg_slot || rec_count > crv_pkg::IDX_MAX) begin
            code = crv_pkg::ST_LENGTH;
         end
         else if (~rec_crc != rec_tail) code = crv_pkg::ST_CRC;
         else code = crv_pkg::ST_VALID;
         res.status       = code;
         res.generation   = rec_gen;
         res.computed_crc = ~rec_crc;
         res.stored_crc   = rec_tail;
         expected_results.push_back(res);
         clear_record();
      end
   endfunction

   // Build one record against the current register shadow and queue its bytes.
   // Defects: one flipped header bit, wrong length, flipped CRC bit, or pure noise.
   task automatic push_record(input rec_kind_type kind);
      logic [7:0]  rec_bytes[$];
      logic [31:0] magic_v;
      logic [31:0] gen_v;
      logic [31:0] crc_v;
      logic [15:0] ver_v;
      logic [15:0] size_v;
      int          len;
      magic_v = cfg_magic;
      ver_v   = cfg_version;
      size_v  = {4'd0, cfg_slot};
      gen_v   = $urandom;
      len     = int'(cfg_slot);
      case (kind)
         REC_BAD_MAGIC:   magic_v ^= 32'd1 << $urandom_range(31);
         REC_BAD_VERSION: ver_v ^= 16'd1 << $urandom_range(15);
         REC_BAD_SIZE:    size_v ^= 16'd1 << $urandom_range(15);
         REC_SHORT:       len = (cfg_slot > 1) ? $urandom_range(int'(cfg_slot) - 1, 1) : 1;
         REC_LONG:        len = int'(cfg_slot) + $urandom_range(4, 1);
         REC_NOISE:       len = $urandom_range(40, 1);
         default: ;
      endcase
      if (len < 1) len = 1;
      // slot values past the maximum can never pass; keep those records short
      if (len > int'(crv_pkg::IDX_SAT) + 3) len = $urandom_range(40, 16);
      if (kind == REC_NOISE) begin
         for (int i = 0; i < len; i++) rec_bytes.push_back(8'($urandom));
      end else begin
         for (int i = 0; i < 4; i++) rec_bytes.push_back(magic_v[i*8 +: 8]);
         for (int i = 0; i < 2; i++) rec_bytes.push_back(ver_v[i*8 +: 8]);
         for (int i = 0; i < 2; i++) rec_bytes.push_back(size_v[i*8 +: 8]);
         for (int i = 0; i < 4; i++) rec_bytes.push_back(gen_v[i*8 +: 8]);
         for (int i = 12; i < len - 4; i++) rec_bytes.push_back(8'($urandom));
         crc_v = crv_pkg::CRC_INIT;
         foreach (rec_bytes[i]) crc_v = crc32_byte(crc_v, rec_bytes[i]);
         crc_v = ~crc_v;
         if (kind == REC_BAD_CRC) crc_v ^= 32'd1 << $urandom_range(31);
         for (int i = 0; i < 4; i++) rec_bytes.push_back(crc_v[i*8 +: 8]);
         // tiny records: cut the full image down to the requested byte count
         while (rec_bytes.size() > len) void'(rec_bytes.pop_back());
      end
      foreach (rec_bytes[i]) begin
         pending_beats.push_back('{data_byte: rec_bytes[i], last: (i == rec_bytes.size() - 1)});
      end
   endtask

   // One register write beat; shadow follows on acceptance. Called at a rising edge.
   task automatic csr_write(input logic [crv_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      case (idx)
         crv_pkg::CSR_MAGIC:   cfg_magic   = val;
         crv_pkg::CSR_VERSION: cfg_version = val[15:0];
         crv_pkg::CSR_SLOT:    cfg_slot    = val[11:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Block is idle once every byte is taken and every verdict is back.
   // Sampled at the falling edge so the driver and monitor updates have settled;
   // returns at a rising edge.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_beats.size() != 0 || req_if.valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Byte driver: holds a beat until it is taken, then maybe inserts a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) track_byte(req_if.data_byte, req_if.last);
         if (pending_beats.size() != 0 && (no_gaps || $urandom_range(99) >= 38)) begin
            next_beat = pending_beats.pop_front();
            req_if.valid     <= 1'b1;
            req_if.data_byte <= next_beat.data_byte;
            req_if.last      <= next_beat.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result monitor: random backpressure, compare each beat with the oldest verdict.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= no_gaps || ($urandom_range(99) >= 38);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("unexpected result: status %0d gen %h comp %h stored %h",
                           rsp_if.status, rsp_if.generation, rsp_if.computed_crc,
                           rsp_if.stored_crc);
               end
            end else begin
               result_want = expected_results.pop_front();
               if (rsp_if.status !== result_want.status ||
                   rsp_if.generation !== result_want.generation ||
                   rsp_if.computed_crc !== result_want.computed_crc ||
                   rsp_if.stored_crc !== result_want.stored_crc) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display({"mismatch (exp/act): status %0d/%0d gen %h/%h",
                               " comp %h/%h stored %h/%h"},
                              result_want.status, rsp_if.status,
                              result_want.generation, rsp_if.generation,
                              result_want.computed_crc, rsp_if.computed_crc,
                              result_want.stored_crc, rsp_if.stored_crc);
                  end
               end
            end
         end
      end
   end

   initial begin
      logic [31:0] word_v;
      logic [11:0] slot_v;
      // known values on every input from time zero
      reset            = 1'b1;
      no_gaps          = 1'b0;
      cycle_count      = 0;
      mismatch_count   = 0;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last      = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = crv_pkg::CSR_MAGIC;
      csr_if.data      = '0;
      cfg_magic        = crv_pkg::MAGIC_RESET;
      cfg_version      = crv_pkg::VERSION_RESET;
      cfg_slot         = crv_pkg::SLOT_RESET;
      clear_record();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: dropped write to the unused index, one good record with the reset
      // register values, then the smallest legal slot with a one-byte record (all ones)
      // and a three-byte record (all zeros) to hit the partial-trailer and empty-CRC corners.
      csr_write(CSR_UNUSED, $urandom);
      push_record(REC_GOOD);
      wait_drained();
      csr_write(crv_pkg::CSR_SLOT, 32'd16);
      pending_beats.push_back('{data_byte: 8'hFF, last: 1'b1});
      pending_beats.push_back('{data_byte: 8'h00, last: 1'b0});
      pending_beats.push_back('{data_byte: 8'h00, last: 1'b0});
      pending_beats.push_back('{data_byte: 8'h00, last: 1'b1});

      // Random phases: new register set each phase, about half the records well-formed.
      // Phase 1 runs a slot past the maximum; phase 2 a tiny slot where header and
      // trailer overlap; phase 5 runs without any gaps.
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         no_gaps <= (p == 5);
         word_v = $urandom;
         case ($urandom_range(3))
            0: word_v = '0;
            1: word_v = '1;
            default: ;
         endcase
         csr_write(crv_pkg::CSR_MAGIC, word_v);
         word_v = $urandom;
         case ($urandom_range(3))
            0: word_v[15:0] = '0;
            1: word_v[15:0] = '1;
            default: ;
         endcase
         csr_write(crv_pkg::CSR_VERSION, word_v);
         case (p)
            0: slot_v = 12'd16;
            1: slot_v = 12'd4095;
            2: slot_v = 12'($urandom_range(15, 0));
            default: slot_v = 12'($urandom_range(32, 17));
         endcase
         word_v = $urandom;
         word_v[11:0] = slot_v;
         csr_write(crv_pkg::CSR_SLOT, word_v);
         if ($urandom_range(2) == 0) csr_write(CSR_UNUSED, $urandom);
         for (int r = 0; r < RECORDS; r++) begin
            push_record(($urandom_range(99) < 50) ? REC_GOOD
                                                  : rec_kind_type'($urandom_range(7, 1)));
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/crv_pkg.sv
hdl/crv_if.sv
hdl/crv_rsp_queue.sv
hdl/config_record_validator_top.sv
verif/tb_top.sv
